FILE: sv/lfu_pkg.sv
// Package for the LFU cache table: sizes, codes, entry word and scan structs.
// Used by lfu_scan, lfu_cache_table and lfu_checker; depends on nothing.
`default_nettype none

package lfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int CAP_W      = 5;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int FILL_W     = $clog2(ENTRIES + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
  localparam logic [CAP_W-1:0]      CAP_RESET = CAP_W'(16);

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [VAL_W-1:0]      value;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             clear;
    logic             step;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  typedef struct packed {
    logic                  hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [VAL_W-1:0]      hit_value;
    logic [COUNT_BITS-1:0] hit_count;
    logic [IDX_W-1:0]      hit_rank;
    logic                  vic_found;
    logic [IDX_W-1:0]      vic_idx;
    logic [COUNT_BITS-1:0] vic_count;
    logic [IDX_W-1:0]      vic_rank;
    logic [KEY_W-1:0]      vic_key;
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;
  } scan_res_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    sat_inc = (c == COUNT_MAX) ? c : c + COUNT_ONE;
  endfunction

endpackage

`default_nettype wire

FILE: sv/lfu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/lfu_scan.sv
// Shared scan unit: one entry per step, tracks key match, eviction victim
// and first free slot. Depends on lfu_pkg.
`default_nettype none

module lfu_scan
  import lfu_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire scan_ctl_t        ctl,
  input  wire logic [KEY_W-1:0] key,
  input  wire logic             ent_valid,
  input  wire logic [IDX_W-1:0] ent_rank,
  input  wire entry_t           ent,
  output scan_res_t             res
);

  logic match;
  logic better;

  assign match  = ent_valid && (ent.key == key) && !res.hit;
  assign better = ent_valid && (!res.vic_found || (ent.count < res.vic_count) ||
                  ((ent.count == res.vic_count) && (ent_rank > res.vic_rank)));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      res.hit        <= 1'b0;
      res.vic_found  <= 1'b0;
      res.free_found <= 1'b0;
    end else if (ctl.step) begin
      if (match) begin
        res.hit       <= 1'b1;
        res.hit_idx   <= ctl.idx;
        res.hit_value <= ent.value;
        res.hit_count <= ent.count;
        res.hit_rank  <= ent_rank;
      end
      if (better) begin
        res.vic_found <= 1'b1;
        res.vic_idx   <= ctl.idx;
        res.vic_count <= ent.count;
        res.vic_rank  <= ent_rank;
        res.vic_key   <= ent.key;
      end
      if (!ent_valid && !res.free_found) begin
        res.free_found <= 1'b1;
        res.free_idx   <= ctl.idx;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/lfu_cache_table.sv
// Top level of the LFU cache table: stream ports, sequencer, valid and rank
// registers, entry RAM. Depends on lfu_pkg, lfu_ram and lfu_scan.
//
// From acceptance, the sequencer reads the entry RAM one entry per cycle
// through the shared scan unit, drains the read latency, then applies the
// update once the output register is free. s_axis_tready is low while an
// item is in progress; a finished result may wait in the output register
// while the next item is taken. Valid bits are cleared at reset, so no
// clearing pass is needed. capacity_in_use is written through cfg_we/cfg_wdata;
// the user must write it only while the block is idle, which the block does not
// enforce. Values above ENTRIES act as ENTRIES and zero makes puts do nothing.
`default_nettype none

module lfu_cache_table
  import lfu_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata,     // capacity_in_use
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [63:0]      s_axis_tdata,  // [31:0] key, [63:32] write_value
  input  wire logic             s_axis_tuser,  // [0] op
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [63:0]      m_axis_tdata,  // [31:0] read_value, [63:32] evicted_key
  output logic      [1:0]       m_axis_tuser   // [0] hit, [1] evicted
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_APPLY
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  cnt;
  logic              ev;
  logic [IDX_W-1:0]  ev_idx;
  op_t               req_op;
  logic [KEY_W-1:0]  req_key;
  logic [VAL_W-1:0]  req_value;
  logic [CAP_W-1:0]  capacity;
  logic [FILL_W-1:0] fill;
  logic              valid [ENTRIES];
  logic [IDX_W-1:0]  rank  [ENTRIES];
  logic              valid_next [ENTRIES];
  logic [IDX_W-1:0]  rank_next  [ENTRIES];

  logic              accept;
  logic              apply_fire;
  logic [FILL_W-1:0] cap_eff;
  logic              is_put;
  logic              cap_zero;
  logic              touch;
  logic              evict;
  logic              ins;
  logic [IDX_W-1:0]  slot;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  entry_t            rd_data;
  scan_ctl_t         scan_ctl;
  scan_res_t         res;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign apply_fire    = (state == S_APPLY) && (!m_axis_tvalid || m_axis_tready);

  assign scan_ctl.clear = accept;
  assign scan_ctl.step  = ev;
  assign scan_ctl.idx   = ev_idx;

  lfu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (state == S_SCAN),
    .raddr (cnt),
    .rdata (rd_data)
  );

  lfu_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (scan_ctl),
    .key       (req_key),
    .ent_valid (valid[ev_idx]),
    .ent_rank  (rank[ev_idx]),
    .ent       (rd_data),
    .res       (res)
  );

  always_comb begin
    if (32'(capacity) > 32'(ENTRIES)) begin
      cap_eff = FILL_W'(ENTRIES);
    end else begin
      cap_eff = FILL_W'(capacity);
    end
    is_put   = (req_op == OP_PUT);
    cap_zero = (cap_eff == '0);
    touch    = res.hit && (!is_put || !cap_zero);
    evict    = is_put && !cap_zero && !res.hit &&
               (32'(fill) >= 32'(cap_eff)) && res.vic_found;
    ins      = is_put && !cap_zero && !res.hit && (evict || res.free_found);
    if (evict && !(res.free_found && (res.free_idx < res.vic_idx))) begin
      slot = res.vic_idx;
    end else begin
      slot = res.free_idx;
    end
    wr_en   = apply_fire && (touch || ins);
    wr_addr = touch ? res.hit_idx : slot;
    wr_data.key = req_key;
    if (touch) begin
      wr_data.value = is_put ? req_value : res.hit_value;
      wr_data.count = sat_inc(res.hit_count);
    end else begin
      wr_data.value = req_value;
      wr_data.count = COUNT_ONE;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid_next[i] = valid[i];
      rank_next[i]  = rank[i];
      if (touch) begin
        if (IDX_W'(i) == res.hit_idx) begin
          rank_next[i] = '0;
        end else if (valid[i] && (rank[i] < res.hit_rank)) begin
          rank_next[i] = rank[i] + 1'b1;
        end
      end
      if (ins) begin
        if (evict && (IDX_W'(i) == res.vic_idx)) begin
          valid_next[i] = 1'b0;
        end else if (valid[i]) begin
          if (evict && (rank[i] > res.vic_rank)) begin
            rank_next[i] = rank[i];
          end else begin
            rank_next[i] = rank[i] + 1'b1;
          end
        end
        if (IDX_W'(i) == slot) begin
          valid_next[i] = 1'b1;
          rank_next[i]  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid[i] <= 1'b0;
      end
      fill     <= '0;
      capacity <= CAP_RESET;
    end else begin
      if (apply_fire) begin
        for (int i = 0; i < ENTRIES; i++) begin
          valid[i] <= valid_next[i];
        end
        if (ins && !evict) begin
          fill <= fill + 1'b1;
        end
      end
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= rank_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      ev            <= 1'b0;
      ev_idx        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      ev     <= (state == S_SCAN);
      ev_idx <= cnt;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cnt       <= '0;
            req_op    <= op_t'(s_axis_tuser);
            req_key   <= s_axis_tdata[31:0];
            req_value <= s_axis_tdata[63:32];
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == IDX_W'(ENTRIES - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (apply_fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (apply_fire) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tuser  <= {evict, touch};
        m_axis_tdata  <= {(evict ? res.vic_key : KEY_W'(0)),
                          ((touch && !is_put) ? res.hit_value : VAL_W'(0))};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/lfu_checker.sv
// Port-level checker for lfu_cache_table, bound to the top level.
// Depends on lfu_pkg and lfu_cache_table.
`default_nettype none

module lfu_checker
  import lfu_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [63:0]      m_axis_tdata,
  input wire logic [1:0]       m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready while an item is in progress");

  a_evict_no_hit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("eviction reported on a hit");

  a_miss_zero_value: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("read value nonzero without hit");

  a_no_evict_zero_key: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[1] |-> (m_axis_tdata[63:32] == 32'd0))
    else $error("evicted key nonzero without eviction");

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
